FILE: hdl/usv_pkg.sv
// Shared types, constants and codes for the UTF-8 stream validator.
package usv_pkg;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [0:0] REG_TOLERATE_TAIL = 1'b0;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// scalar value limits
	localparam logic [20:0] CP_MIN_2 = 21'h000080;
	localparam logic [20:0] CP_MIN_3 = 21'h000800;
	localparam logic [20:0] CP_MIN_4 = 21'h010000;
	localparam logic [20:0] CP_SURR_LO = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	// lead byte bounds
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	// byte order mark codes
	localparam logic [2:0] BOM_NONE = 3'd0;
	localparam logic [2:0] BOM_UTF8 = 3'd1;
	localparam logic [2:0] BOM_UTF16LE = 3'd2;
	localparam logic [2:0] BOM_UTF16BE = 3'd3;
	localparam logic [2:0] BOM_UTF32LE = 3'd4;
	localparam logic [2:0] BOM_UTF32BE = 3'd5;

	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_CONT = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD = 3'd5
	} byte_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} byte_item_t;

	typedef struct packed {
		logic utf8_valid;
		logic [2:0] bom_kind;
	} verdict_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		byte_class_t cls;
		logic [5:0] payload;
		logic [7:0] raw;
		logic last;
	} queue_entry_t;

endpackage

FILE: hdl/utf8_stream_validator.sv
// Strict UTF-8 byte stream validator: top level with the configuration port.
// Throughput: one byte per cycle while the queue has room; the verdict may wait on the output
// while bytes flow in, but a later last byte is held until that verdict is taken. The last
// byte is registered in the four-entry classified-byte queue, then in the output register.
// Reset: asynchronous, clears the stream state and queue, tolerate_tail returns to 0.
module utf8_stream_validator
	import usv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	input  logic byte_valid,
	output logic byte_ready,
	input  byte_item_t byte_item,
	output logic verdict_valid,
	input  logic verdict_ready,
	output verdict_t verdict
);

	logic tolerate_q;
	logic push_valid;
	logic push_ready;
	queue_entry_t push_entry;
	logic pop_valid;
	logic pop_ready;
	queue_entry_t pop_entry;
	logic reg_sel;

	assign pready = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_TOLERATE_TAIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerate_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tolerate_q <= pwdata[0];
		end
	end

	assign prdata = reg_sel ? {{(APB_DATA_W-1){1'b0}}, tolerate_q} : '0;

	usv_front u_front (
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	usv_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	usv_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.tolerate_tail (tolerate_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.verdict (verdict)
	);

endmodule

FILE: hdl/usv_front.sv
// Front end: accepts stream bytes and classifies them for the queue.
module usv_front
	import usv_pkg::*;
(
	input  logic byte_valid,
	output logic byte_ready,
	input  byte_item_t byte_item,
	output logic push_valid,
	input  logic push_ready,
	output queue_entry_t push_entry
);

	logic [7:0] b;

	assign b = byte_item.data_byte;
	assign byte_ready = push_ready;
	assign push_valid = byte_valid;

	always_comb begin
		push_entry.raw = b;
		push_entry.last = byte_item.last_byte;
		push_entry.payload = 6'd0;
		push_entry.cls = CLS_BAD;
		if (b[7] == 1'b0) begin
			push_entry.cls = CLS_ASCII;
		end else if (b[7:6] == 2'b10) begin
			push_entry.cls = CLS_CONT;
			push_entry.payload = b[5:0];
		end else if (b[7:5] == 3'b110) begin
			// C0 and C1 can only start overlong forms
			if (b >= LEAD2_MIN) begin
				push_entry.cls = CLS_LEAD2;
				push_entry.payload = {1'b0, b[4:0]};
			end
		end else if (b[7:4] == 4'b1110) begin
			push_entry.cls = CLS_LEAD3;
			push_entry.payload = {2'b00, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			if (b <= LEAD4_MAX) begin
				push_entry.cls = CLS_LEAD4;
				push_entry.payload = {3'b000, b[2:0]};
			end
		end
	end

endmodule

FILE: hdl/usv_queue.sv
// Short FIFO of classified bytes between front and back.
module usv_queue
	import usv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  queue_entry_t push_entry,
	output logic pop_valid,
	input  logic pop_ready,
	output queue_entry_t pop_entry
);

	queue_entry_t entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = entries_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/usv_back.sv
// Back end: sequence tracking, mark capture and the registered verdict.
module usv_back
	import usv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tolerate_tail,
	input  logic pop_valid,
	output logic pop_ready,
	input  queue_entry_t pop_entry,
	output logic verdict_valid,
	input  logic verdict_ready,
	output verdict_t verdict
);

	logic [1:0] pending_q;
	logic [1:0] seq_len_q;
	logic [20:0] code_point_q;
	logic error_q;
	logic ok_seg_q;
	logic [7:0] head_q [4];
	logic [2:0] head_cnt_q;
	logic out_valid_q;
	verdict_t out_q;

	logic [1:0] pending_n;
	logic [1:0] seq_len_n;
	logic [20:0] code_point_n;
	logic error_n;
	logic ok_seg_n;
	logic [7:0] head_n [4];
	logic [2:0] head_cnt_n;
	logic [20:0] cp_min;
	logic valid_n;
	logic [2:0] bom_n;
	logic take;

	// a non-final byte never waits on the output side
	assign pop_ready = !pop_entry.last || !out_valid_q || verdict_ready;
	assign take = pop_valid && pop_ready;
	assign verdict_valid = out_valid_q;
	assign verdict = out_q;

	always_comb begin
		case (seq_len_q)
			2'd1: cp_min = CP_MIN_2;
			2'd2: cp_min = CP_MIN_3;
			default: cp_min = CP_MIN_4;
		endcase
	end

	always_comb begin
		head_n = head_q;
		head_cnt_n = head_cnt_q;
		if (head_cnt_q[2] == 1'b0) begin
			head_n[head_cnt_q[1:0]] = pop_entry.raw;
			head_cnt_n = head_cnt_q + 3'd1;
		end

		pending_n = pending_q;
		seq_len_n = seq_len_q;
		code_point_n = code_point_q;
		error_n = error_q;
		ok_seg_n = ok_seg_q;
		if (pop_entry.cls == CLS_CONT) begin
			if (pending_q == 2'd0) begin
				error_n = 1'b1;
			end else begin
				code_point_n = {code_point_q[14:0], pop_entry.payload};
				pending_n = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					if (code_point_n < cp_min) error_n = 1'b1;
					if (code_point_n >= CP_SURR_LO && code_point_n <= CP_SURR_HI) begin
						error_n = 1'b1;
					end
					if (code_point_n > CP_MAX) error_n = 1'b1;
				end
			end
		end else begin
			// snapshot the verdict before this segment starts
			ok_seg_n = !error_q && (pending_q == 2'd0);
			if (pending_q != 2'd0) begin
				error_n = 1'b1;
				pending_n = 2'd0;
			end
			case (pop_entry.cls)
				CLS_ASCII: ;
				CLS_LEAD2: begin
					pending_n = 2'd1;
					seq_len_n = 2'd1;
					code_point_n = {15'd0, pop_entry.payload};
				end
				CLS_LEAD3: begin
					pending_n = 2'd2;
					seq_len_n = 2'd2;
					code_point_n = {15'd0, pop_entry.payload};
				end
				CLS_LEAD4: begin
					pending_n = 2'd3;
					seq_len_n = 2'd3;
					code_point_n = {15'd0, pop_entry.payload};
				end
				default: error_n = 1'b1;
			endcase
		end

		valid_n = tolerate_tail ? ok_seg_n : (!error_n && pending_n == 2'd0);

		// UTF-32 marks take priority over the shorter ones
		if (head_cnt_n[2] && head_n[0] == 8'h00 && head_n[1] == 8'h00
				&& head_n[2] == 8'hFE && head_n[3] == 8'hFF) begin
			bom_n = BOM_UTF32BE;
		end else if (head_cnt_n[2] && head_n[0] == 8'hFF && head_n[1] == 8'hFE
				&& head_n[2] == 8'h00 && head_n[3] == 8'h00) begin
			bom_n = BOM_UTF32LE;
		end else if (head_cnt_n >= 3'd3 && head_n[0] == 8'hEF && head_n[1] == 8'hBB
				&& head_n[2] == 8'hBF) begin
			bom_n = BOM_UTF8;
		end else if (head_cnt_n >= 3'd2 && head_n[0] == 8'hFF && head_n[1] == 8'hFE) begin
			bom_n = BOM_UTF16LE;
		end else if (head_cnt_n >= 3'd2 && head_n[0] == 8'hFE && head_n[1] == 8'hFF) begin
			bom_n = BOM_UTF16BE;
		end else begin
			bom_n = BOM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			seq_len_q <= 2'd0;
			code_point_q <= 21'd0;
			error_q <= 1'b0;
			ok_seg_q <= 1'b1;
			head_q <= '{default: 8'h00};
			head_cnt_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && pop_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (verdict_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (pop_entry.last) begin
					// stream done: return to the start-of-stream state
					pending_q <= 2'd0;
					seq_len_q <= 2'd0;
					code_point_q <= 21'd0;
					error_q <= 1'b0;
					ok_seg_q <= 1'b1;
					head_q <= '{default: 8'h00};
					head_cnt_q <= 3'd0;
				end else begin
					pending_q <= pending_n;
					seq_len_q <= seq_len_n;
					code_point_q <= code_point_n;
					error_q <= error_n;
					ok_seg_q <= ok_seg_n;
					head_q <= head_n;
					head_cnt_q <= head_cnt_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_entry.last) begin
			out_q.utf8_valid <= valid_n;
			out_q.bom_kind <= bom_n;
		end
	end

endmodule

FILE: verif/utf8_stream_validator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the strict UTF-8 stream validator.
module testbench;
	import usv_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_PHASE_BYTES = 250;
	localparam logic [APB_ADDR_W-1:0] TOLERATE_TAIL_ADDR = APB_ADDR_W'(4 * REG_TOLERATE_TAIL);
	localparam verdict_t NO_VERDICT = '0;

	localparam logic [20:0] BOUNDARY_SCALARS [9] = '{
		21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
		21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
	};

	// mode_row: write tolerate_tail from data[0]; typed: want is the expected verdict
	typedef struct packed {
		logic mode_row;
		logic [7:0] data;
		logic last;
		logic typed;
		verdict_t want;
	} step_row_t;

	localparam step_row_t DIRECTED_STEPS [34] = '{
		'{1'b1, 8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h00, 1'b1, 1'b1, '{1'b1, BOM_NONE}},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hFE, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h00, 1'b1, 1'b1, '{1'b0, BOM_UTF32LE}},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hFE, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hFF, 1'b1, 1'b1, '{1'b0, BOM_UTF32BE}},
		'{1'b0, 8'hEF, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hBB, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hBF, 1'b1, 1'b1, '{1'b1, BOM_UTF8}},
		// bad lead C0 followed by an orphan continuation
		'{1'b0, 8'hFE, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hC0, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b1, 1'b1, '{1'b0, BOM_UTF16BE}},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hFE, 1'b1, 1'b1, '{1'b0, BOM_UTF16LE}},
		// surrogate D800
		'{1'b0, 8'hED, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hA0, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b1, 1'b1, '{1'b0, BOM_NONE}},
		// scalar 110000, one past the top
		'{1'b0, 8'hF4, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h90, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b1, 1'b1, '{1'b0, BOM_NONE}},
		'{1'b1, 8'h01, 1'b0, 1'b0, NO_VERDICT},
		// truncated tail, then a stream of one continuation byte
		'{1'b0, 8'hE2, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h82, 1'b1, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b1, 1'b0, NO_VERDICT},
		// lead byte cut off by ASCII while a sequence is pending
		'{1'b0, 8'hC2, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h41, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'hE0, 1'b0, 1'b0, NO_VERDICT},
		'{1'b0, 8'h80, 1'b1, 1'b0, NO_VERDICT}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic byte_valid = 1'b0;
	logic byte_ready;
	byte_item_t byte_item = '0;
	logic verdict_valid;
	logic verdict_ready = 1'b0;
	verdict_t verdict;

	// predictor state
	logic [1:0] pend_cnt;
	logic [1:0] seq_len;
	logic [20:0] cp_acc;
	logic err_sticky;
	logic ok_snap;
	logic [7:0] head_bytes [4];
	logic [2:0] head_cnt;
	logic tol_tail_cfg = 1'b0;

	verdict_t pending_verdicts [$];
	logic [7:0] stream_q [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned byte_count = 0;
	int unsigned stream_count = 0;
	int unsigned verdict_count = 0;

	utf8_stream_validator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.verdict_valid(verdict_valid),
		.verdict_ready(verdict_ready),
		.verdict(verdict)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void restart_stream();
		pend_cnt = '0;
		seq_len = '0;
		cp_acc = '0;
		err_sticky = 1'b0;
		ok_snap = 1'b1;
		for (int k = 0; k < 4; k++) head_bytes[k] = '0;
		head_cnt = '0;
	endfunction

	// Advance the stream state by one byte; return 1 with the verdict on the last byte.
	function automatic logic judge_byte(input byte_item_t it, output verdict_t v);
		logic [7:0] b;
		logic [20:0] floor_cp;
		v = '0;
		b = it.data_byte;
		if (head_cnt < 4) begin
			head_bytes[head_cnt[1:0]] = b;
			head_cnt++;
		end
		if (b[7:6] == 2'b10) begin
			if (pend_cnt == 0) begin
				err_sticky = 1'b1;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				pend_cnt--;
				if (pend_cnt == 0) begin
					floor_cp = (seq_len == 1) ? CP_MIN_2 : (seq_len == 2) ? CP_MIN_3 : CP_MIN_4;
					if (cp_acc < floor_cp || cp_acc > CP_MAX ||
						(cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI))
						err_sticky = 1'b1;
				end
			end
		end else begin
			ok_snap = !err_sticky && pend_cnt == 0;
			// drop an unfinished sequence
			if (pend_cnt != 0) begin
				err_sticky = 1'b1;
				pend_cnt = '0;
			end
			if (b[7:5] == 3'b110) begin
				if (b < LEAD2_MIN) begin
					err_sticky = 1'b1;
				end else begin
					pend_cnt = 2'd1;
					seq_len = 2'd1;
					cp_acc = {16'b0, b[4:0]};
				end
			end else if (b[7:4] == 4'b1110) begin
				pend_cnt = 2'd2;
				seq_len = 2'd2;
				cp_acc = {17'b0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				if (b > LEAD4_MAX) begin
					err_sticky = 1'b1;
				end else begin
					pend_cnt = 2'd3;
					seq_len = 2'd3;
					cp_acc = {18'b0, b[2:0]};
				end
			end else if (b[7]) begin
				err_sticky = 1'b1;
			end
		end
		if (!it.last_byte) return 1'b0;

		v.utf8_valid = tol_tail_cfg ? ok_snap : (!err_sticky && pend_cnt == 0);
		if (head_cnt >= 4 && head_bytes[0] == 8'h00 && head_bytes[1] == 8'h00 &&
			head_bytes[2] == 8'hFE && head_bytes[3] == 8'hFF)
			v.bom_kind = BOM_UTF32BE;
		else if (head_cnt >= 4 && head_bytes[0] == 8'hFF && head_bytes[1] == 8'hFE &&
			head_bytes[2] == 8'h00 && head_bytes[3] == 8'h00)
			v.bom_kind = BOM_UTF32LE;
		else if (head_cnt >= 3 && head_bytes[0] == 8'hEF && head_bytes[1] == 8'hBB &&
			head_bytes[2] == 8'hBF)
			v.bom_kind = BOM_UTF8;
		else if (head_cnt >= 2 && head_bytes[0] == 8'hFF && head_bytes[1] == 8'hFE)
			v.bom_kind = BOM_UTF16LE;
		else if (head_cnt >= 2 && head_bytes[0] == 8'hFE && head_bytes[1] == 8'hFF)
			v.bom_kind = BOM_UTF16BE;
		else
			v.bom_kind = BOM_NONE;
		restart_stream();
		return 1'b1;
	endfunction

	function automatic int unsigned utf8_len(input logic [20:0] cp);
		return (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
	endfunction

	// Encode cp in exactly len bytes; a longer len than needed gives an overlong form.
	function automatic void encode_scalar(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: stream_q.push_back({1'b0, cp[6:0]});
			2: begin
				stream_q.push_back({3'b110, cp[10:6]});
				stream_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				stream_q.push_back({4'b1110, cp[15:12]});
				stream_q.push_back({2'b10, cp[11:6]});
				stream_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				stream_q.push_back({5'b11110, cp[20:18]});
				stream_q.push_back({2'b10, cp[17:12]});
				stream_q.push_back({2'b10, cp[11:6]});
				stream_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic void build_stream();
		int unsigned n;
		int unsigned pick;
		int unsigned len;
		logic [20:0] cp;
		stream_q.delete();
		// raw noise
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(1, 8);
			repeat (n) stream_q.push_back(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(4))
				0: begin stream_q.push_back(8'hEF); stream_q.push_back(8'hBB);
					stream_q.push_back(8'hBF); end
				1: begin stream_q.push_back(8'hFF); stream_q.push_back(8'hFE); end
				2: begin stream_q.push_back(8'hFE); stream_q.push_back(8'hFF); end
				3: begin stream_q.push_back(8'hFF); stream_q.push_back(8'hFE);
					stream_q.push_back(8'h00); stream_q.push_back(8'h00); end
				default: begin stream_q.push_back(8'h00); stream_q.push_back(8'h00);
					stream_q.push_back(8'hFE); stream_q.push_back(8'hFF); end
			endcase
		end
		n = $urandom_range(1, 8);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 33) begin
				encode_scalar(21'($urandom_range(8'h7F)), 1);
			end else if (pick < 52) begin
				encode_scalar(21'($urandom_range(12'h7FF, 8'h80)), 2);
			end else if (pick < 70) begin
				cp = 21'($urandom_range(16'hFFFF, 12'h800));
				if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp + 21'h2000;
				encode_scalar(cp, 3);
			end else if (pick < 82) begin
				encode_scalar(21'($urandom_range(21'h10FFFF, 21'h10000)), 4);
			end else if (pick < 88) begin
				cp = BOUNDARY_SCALARS[$urandom_range(8)];
				encode_scalar(cp, utf8_len(cp));
			end else begin
				case ($urandom_range(6))
					0: encode_scalar(21'($urandom_range(8'h7F)), 2);
					1: encode_scalar(21'($urandom_range(12'h7FF)), 3);
					2: encode_scalar(21'($urandom_range(16'hFFFF)), 4);
					3: encode_scalar(21'($urandom_range(CP_SURR_HI, CP_SURR_LO)), 3);
					4: encode_scalar(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
					5: stream_q.push_back(8'($urandom_range(8'hFF, 8'h80)));
					default: begin
						len = $urandom_range(4, 3);
						encode_scalar(21'($urandom_range(21'h10FFFF, 21'h800)), len);
						repeat ($urandom_range(len - 1, 1)) void'(stream_q.pop_back());
					end
				endcase
			end
		end
		// truncated trailing segment
		if ($urandom_range(99) < 20) begin
			len = $urandom_range(4, 2);
			cp = (len == 2) ? 21'($urandom_range(12'h7FF, 8'h80)) :
				(len == 3) ? 21'($urandom_range(16'hFFFF, 12'h800)) :
				21'($urandom_range(21'h10FFFF, 21'h10000));
			encode_scalar(cp, len);
			repeat ($urandom_range(len - 1, 1)) void'(stream_q.pop_back());
		end
	endfunction

	// Offer one byte, hold it until the transfer, then on a last byte record the expected verdict.
	task automatic push_byte(input byte_item_t it, input logic typed, input verdict_t want);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (!byte_ready);
		byte_count++;
		if (it.last_byte) stream_count++;
		if (judge_byte(it, v)) pending_verdicts.push_back(typed ? want : v);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TOLERATE_TAIL_ADDR;
		pwdata <= {{(APB_DATA_W - 1){1'b0}}, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tol_tail_cfg = mode;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(APB_DATA_W - 1){1'b0}}, mode}) begin
			$error("prdata: expected %0h, got %0h", mode, prdata);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ready <= 1'b0;
		end else begin
			verdict_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && verdict_valid && verdict_ready) begin
			verdict_count++;
			if (pending_verdicts.size() == 0) begin
				$error("verdict: none expected, got valid %0d mark %0d",
					verdict.utf8_valid, verdict.bom_kind);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict.utf8_valid !== want.utf8_valid) begin
					$error("utf8_valid: expected %0d, got %0d", want.utf8_valid,
						verdict.utf8_valid);
					mismatch_count++;
				end
				if (verdict.bom_kind !== want.bom_kind) begin
					$error("bom_kind: expected %0d, got %0d", want.bom_kind, verdict.bom_kind);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		byte_item_t item;
		int unsigned phase_start;
		restart_stream();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 62;
		for (int r = 0; r < $size(DIRECTED_STEPS); r++) begin
			if (DIRECTED_STEPS[r].mode_row) begin
				wait_drained();
				write_tolerance(DIRECTED_STEPS[r].data[0]);
			end else begin
				item.data_byte = DIRECTED_STEPS[r].data;
				item.last_byte = DIRECTED_STEPS[r].last;
				push_byte(item, DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].want);
			end
		end

		// two tail modes under each idle pattern
		for (int phase = 0; phase < 6; phase++) begin
			send_idle_pct = (phase < 2) ? 9 : (phase < 4) ? 62 : 0;
			recv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 9 : 0;
			wait_drained();
			write_tolerance(phase[0]);
			phase_start = byte_count;
			while (byte_count - phase_start < RANDOM_PHASE_BYTES) begin
				build_stream();
				for (int i = 0; i < stream_q.size(); i++) begin
					item.data_byte = stream_q[i];
					item.last_byte = (i == stream_q.size() - 1);
					push_byte(item, 1'b0, NO_VERDICT);
				end
			end
		end
		wait_drained();

		$display("Sent %0d bytes in %0d streams, checked %0d verdicts,", byte_count,
			stream_count, verdict_count);
		$display("in strict and tolerant tail modes under three idle patterns.");
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
